// ----- src/pft_pkg.sv -----
// Shared types and constants of the pedestal threshold pulse finder.
`default_nettype none
package pft_pkg;

    localparam int SAMPLE_W = 12;
    localparam int INDEX_W  = 12;
    localparam int COUNT_W  = 12;
    localparam int CFG_W    = 4;
    localparam int SQ_W     = 2 * CFG_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // configuration register indexes
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_END_BAND  = 1'b1;

    localparam logic [CFG_W-1:0] THRESHOLD_RST = 4'd5;
    localparam logic [CFG_W-1:0] END_BAND_RST  = 4'd1;

    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_SHORT = 1'b1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last_of_island;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic [INDEX_W-1:0] start_index;
        logic [COUNT_W-1:0] pulse_count;
        logic               status;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic start_ok;
        logic end_ok;
    } t_judge_res;

endpackage
`default_nettype wire

// ----- src/pft_in_if.sv -----
// Sample channel: valid/ready handshake with one sample per transaction.
`default_nettype none
interface pft_in_if;
    logic              valid;
    logic              ready;
    pft_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/pft_out_if.sv -----
// Result channel: valid/ready handshake with one result per transaction.
`default_nettype none
interface pft_out_if;
    logic               valid;
    logic               ready;
    pft_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/pft_head_mem.sv -----
// Head sample store: one write port, one read port, registered read data.
`default_nettype none
module pft_head_mem #(
    parameter int DEPTH = 10,
    parameter int WIDTH = 12
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- src/pft_judge.sv -----
// Start and end tests for one sample index, as a five stage pipeline.
`default_nettype none
module pft_judge #(
    parameter int PEDESTAL_LEN = 10,
    parameter int SAMPLE_BITS  = 12,
    localparam int LW = $clog2(PEDESTAL_LEN + 1),
    localparam int CW = $clog2(PEDESTAL_LEN),
    localparam int SW = SAMPLE_BITS + CW,
    localparam int VW = 2 * SAMPLE_BITS + CW + LW
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_go,
    input  wire logic [SAMPLE_BITS-1:0]   i_a,
    input  wire logic [SAMPLE_BITS-1:0]   i_b,
    input  wire logic [SAMPLE_BITS-1:0]   i_c,
    input  wire logic [SW-1:0]            i_sum,
    input  wire logic [VW-1:0]            i_var,
    input  wire logic [pft_pkg::SQ_W-1:0] i_k_sq,
    input  wire logic [pft_pkg::SQ_W-1:0] i_e_sq,
    output logic                          o_done,
    output pft_pkg::t_judge_res           o_res
);

    localparam int SB  = SAMPLE_BITS;
    localparam int XW  = SB + LW;
    localparam int KW  = VW + pft_pkg::SQ_W;
    localparam int TW  = SB + 2;
    localparam int RSH = TW + 2;
    localparam int PW  = TW + RSH;
    localparam logic [RSH-1:0] RECIP = RSH'((1 << RSH) / 3);
    localparam logic [XW-1:0]  L_X   = XW'(PEDESTAL_LEN);

    // stage 1
    logic            r1_v, r1_lt;
    logic [SW-1:0]   r1_d;
    logic [TW-1:0]   r1_sum;
    logic [PW-1:0]   r1_prod;
    logic [KW-1:0]   r1_kv, r1_ev;
    logic [XW-1:0]   r1_s;
    // stage 2
    logic            r2_v, r2_lt;
    logic [SB-1:0]   r2_m;
    logic [2*SW-1:0] r2_dd;
    logic [KW-1:0]   r2_kv, r2_ev;
    logic [XW-1:0]   r2_s;
    // stage 3
    logic            r3_v, r3_lt;
    logic [XW-1:0]   r3_x;
    logic [2*SW-1:0] r3_dd;
    logic [KW-1:0]   r3_kv, r3_ev;
    // stage 4
    logic            r4_v, r4_lt;
    logic [2*XW-1:0] r4_xx;
    logic [2*SW-1:0] r4_dd;
    logic [KW-1:0]   r4_kv, r4_ev;

    logic [XW-1:0] la, lb, s_x, lm;
    logic [TW-1:0] q_est, q_rem, m_full;

    always_comb begin
        s_x    = XW'(i_sum);
        la     = XW'(i_a) * L_X;
        lb     = XW'(i_b) * L_X;
        q_est  = TW'(r1_prod >> RSH);
        q_rem  = r1_sum - ((q_est << 1) + q_est);
        m_full = (q_rem >= TW'(3)) ? q_est + TW'(1) : q_est;
        lm     = XW'(r2_m) * L_X;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v   <= 1'b0;
            r2_v   <= 1'b0;
            r3_v   <= 1'b0;
            r4_v   <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r1_v   <= i_go;
            r2_v   <= r1_v;
            r3_v   <= r2_v;
            r4_v   <= r3_v;
            o_done <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_lt   <= (la < s_x) && (lb < s_x);
        r1_d    <= SW'(s_x - lb);
        r1_sum  <= TW'(i_a) + TW'(i_b) + TW'(i_c);
        r1_prod <= (PW'(i_a) + PW'(i_b) + PW'(i_c)) * PW'(RECIP);
        r1_kv   <= KW'(i_k_sq) * KW'(i_var);
        r1_ev   <= KW'(i_e_sq) * KW'(i_var);
        r1_s    <= s_x;

        r2_lt <= r1_lt;
        r2_m  <= SB'(m_full);
        r2_dd <= (2*SW)'(r1_d) * (2*SW)'(r1_d);
        r2_kv <= r1_kv;
        r2_ev <= r1_ev;
        r2_s  <= r1_s;

        r3_lt <= r2_lt;
        r3_x  <= (lm >= r2_s) ? lm - r2_s : r2_s - lm;
        r3_dd <= r2_dd;
        r3_kv <= r2_kv;
        r3_ev <= r2_ev;

        r4_lt <= r3_lt;
        r4_xx <= (2*XW)'(r3_x) * (2*XW)'(r3_x);
        r4_dd <= r3_dd;
        r4_kv <= r3_kv;
        r4_ev <= r3_ev;

        o_res.start_ok <= r4_lt && (KW'(r4_dd) > r4_kv);
        o_res.end_ok   <= KW'(r4_xx) < r4_ev;
    end

endmodule
`default_nettype wire

// ----- src/pedestal_threshold_pulse_finder.sv -----
// Top level: island sequencer, pedestal sums, head store and result register.
//
//  channel       dir  payload                                      handshake
//  i_sample_ch   in   sample, last_of_island                       valid/ready
//  o_result_ch   out  kind, start_index, pulse_count, status, last valid/ready
//  i_cfg_*       in   index 0 threshold_sigma, 1 end_band_sigma    write enable
//
// Samples inside the pedestal window are taken without leaving the idle state; a later
// sample runs the judge before the next is taken, and the last of an island also runs
// the final index and the summary. The sample that closes the window replays the head:
// it is read back one entry at a time and every index passes the judge pipeline. Reset
// is synchronous and needs no clearing pass. A stalled result register holds the
// sequencer only when it has a new result to load.
`default_nettype none
module pedestal_threshold_pulse_finder #(
    parameter int PEDESTAL_LEN = 10,
    parameter int SAMPLE_BITS  = 12,
    parameter int MAX_ISLAND   = 4096
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    pft_in_if.sink                         i_sample_ch,
    pft_out_if.source                      o_result_ch,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_idx,
    input  wire logic [pft_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int SB = SAMPLE_BITS;
    localparam int LW = $clog2(PEDESTAL_LEN + 1);
    localparam int CW = $clog2(PEDESTAL_LEN);
    localparam int SW = SB + CW;
    localparam int QW = 2 * SB + CW;
    localparam int VW = QW + LW;
    localparam int PSW = $clog2(MAX_ISLAND + 1);
    localparam int QSW = pft_pkg::SQ_W;

    localparam logic [PSW-1:0] POS_HEAD_END = PSW'(PEDESTAL_LEN - 1);
    localparam logic [PSW-1:0] POS_REPLAY_END = PSW'(PEDESTAL_LEN - 3);
    localparam logic [PSW-1:0] POS_MAX = PSW'(MAX_ISLAND);

    typedef enum logic [3:0] {
        S_IDLE, S_VAR0, S_VAR1, S_RD, S_RDQ, S_JGO, S_JWAIT, S_JDONE, S_POST, S_SUMMARY
    } t_state;

    typedef enum logic [1:0] {
        PH_REPLAY, PH_LIVE, PH_TAIL
    } t_phase;

    t_state r_state;
    t_phase r_phase;

    logic [QSW-1:0]             r_k_sq, r_e_sq;
    logic [SW-1:0]              r_sum;
    logic [QW-1:0]              r_sq_sum;
    logic [2*SW-1:0]            r_ss;
    logic [VW-1:0]              r_lq, r_var;
    logic [SB-1:0]              r_r0, r_r1, r_c;
    logic [PSW-1:0]             r_pos, r_idx;
    logic                       r_open, r_full, r_last, r_status;
    logic [pft_pkg::COUNT_W-1:0] r_count;
    logic [CW-1:0]              r_rd_addr;
    logic [1:0]                 r_fill;
    pft_pkg::t_judge_res        r_res;
    logic                       r_out_valid;
    pft_pkg::t_out_item         r_out_data;

    logic                accept, out_free, mem_we, mem_re, start, open_next, jdone;
    logic [SB-1:0]       s_in, mem_q;
    pft_pkg::t_judge_res jres;

    assign s_in     = SB'(i_sample_ch.data.sample);
    assign accept   = i_sample_ch.valid && i_sample_ch.ready;
    assign out_free = !r_out_valid || o_result_ch.ready;
    assign mem_we   = accept && (r_pos <= POS_HEAD_END);
    assign mem_re   = (r_state == S_RD);

    assign i_sample_ch.ready = (r_state == S_IDLE);
    assign o_result_ch.valid = r_out_valid;
    assign o_result_ch.data  = r_out_data;

    always_comb begin
        start     = !r_open && r_res.start_ok;
        open_next = r_open || start;
        if (open_next && r_full && r_res.end_ok) begin
            open_next = 1'b0;
        end
    end

    pft_head_mem #(
        .DEPTH (PEDESTAL_LEN),
        .WIDTH (SB)
    ) u_head_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_pos[CW-1:0]),
        .i_wdata (s_in),
        .i_re    (mem_re),
        .i_raddr (r_rd_addr),
        .o_rdata (mem_q)
    );

    pft_judge #(
        .PEDESTAL_LEN (PEDESTAL_LEN),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_judge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_state == S_JGO),
        .i_a     (r_r0),
        .i_b     (r_r1),
        .i_c     (r_c),
        .i_sum   (r_sum),
        .i_var   (r_var),
        .i_k_sq  (r_k_sq),
        .i_e_sq  (r_e_sq),
        .o_done  (jdone),
        .o_res   (jres)
    );

    // configuration: keep the squared multipliers only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_sq <= QSW'(pft_pkg::THRESHOLD_RST) * QSW'(pft_pkg::THRESHOLD_RST);
            r_e_sq <= QSW'(pft_pkg::END_BAND_RST) * QSW'(pft_pkg::END_BAND_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pft_pkg::CFG_THRESHOLD: r_k_sq <= QSW'(i_cfg_data) * QSW'(i_cfg_data);
                pft_pkg::CFG_END_BAND:  r_e_sq <= QSW'(i_cfg_data) * QSW'(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_LIVE;
            r_sum       <= '0;
            r_sq_sum    <= '0;
            r_r0        <= '0;
            r_r1        <= '0;
            r_pos       <= '0;
            r_open      <= 1'b0;
            r_count     <= '0;
            r_status    <= pft_pkg::STATUS_OK;
            r_last      <= 1'b0;
            r_full      <= 1'b0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_result_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_last <= i_sample_ch.data.last_of_island;
                        if (r_pos <= POS_HEAD_END) begin
                            r_sum    <= r_sum + SW'(s_in);
                            r_sq_sum <= r_sq_sum + QW'((2*SB)'(s_in) * (2*SB)'(s_in));
                        end
                        if (r_pos < POS_HEAD_END) begin
                            if (i_sample_ch.data.last_of_island) begin
                                r_status <= pft_pkg::STATUS_SHORT;
                                r_state  <= S_SUMMARY;
                            end else begin
                                r_pos <= r_pos + PSW'(1);
                            end
                        end else if (r_pos == POS_HEAD_END) begin
                            r_state <= S_VAR0;
                        end else begin
                            r_c     <= s_in;
                            r_idx   <= r_pos - PSW'(2);
                            r_phase <= PH_LIVE;
                            r_full  <= 1'b1;
                            r_state <= S_JGO;
                        end
                    end
                end
                S_VAR0: begin
                    r_ss    <= (2*SW)'(r_sum) * (2*SW)'(r_sum);
                    r_lq    <= VW'(r_sq_sum) * VW'(PEDESTAL_LEN);
                    r_state <= S_VAR1;
                end
                S_VAR1: begin
                    r_var     <= (r_lq > VW'(r_ss)) ? r_lq - VW'(r_ss) : '0;
                    r_rd_addr <= '0;
                    r_fill    <= '0;
                    r_idx     <= '0;
                    r_phase   <= PH_REPLAY;
                    r_full    <= 1'b1;
                    r_state   <= S_RD;
                end
                S_RD: begin
                    r_state <= S_RDQ;
                end
                S_RDQ: begin
                    r_rd_addr <= r_rd_addr + CW'(1);
                    unique case (r_fill)
                        2'd0: begin
                            r_r0    <= mem_q;
                            r_fill  <= 2'd1;
                            r_state <= S_RD;
                        end
                        2'd1: begin
                            r_r1    <= mem_q;
                            r_fill  <= 2'd2;
                            r_state <= S_RD;
                        end
                        default: begin
                            r_c     <= mem_q;
                            r_state <= S_JGO;
                        end
                    endcase
                end
                S_JGO: begin
                    r_state <= S_JWAIT;
                end
                S_JWAIT: begin
                    if (jdone) begin
                        r_res   <= jres;
                        r_state <= S_JDONE;
                    end
                end
                S_JDONE: begin
                    // hold a start until the result register can take it
                    if (!start || out_free) begin
                        if (start) begin
                            r_out_valid            <= 1'b1;
                            r_out_data.kind        <= pft_pkg::KIND_START;
                            r_out_data.start_index <= pft_pkg::INDEX_W'(r_idx);
                            r_out_data.pulse_count <= '0;
                            r_out_data.status      <= pft_pkg::STATUS_OK;
                            r_out_data.last        <= 1'b0;
                            if (r_count != pft_pkg::COUNT_MAX) begin
                                r_count <= r_count + pft_pkg::COUNT_W'(1);
                            end
                        end
                        r_open <= open_next;
                        unique case (r_phase)
                            PH_TAIL: r_state <= S_SUMMARY;
                            PH_LIVE: begin
                                r_r0    <= r_r1;
                                r_r1    <= r_c;
                                r_state <= S_POST;
                            end
                            default: begin
                                r_r0 <= r_r1;
                                r_r1 <= r_c;
                                if (r_idx == POS_REPLAY_END) begin
                                    r_state <= S_POST;
                                end else begin
                                    r_idx   <= r_idx + PSW'(1);
                                    r_state <= S_RD;
                                end
                            end
                        endcase
                    end
                end
                S_POST: begin
                    if (r_last) begin
                        // final index gets the start test only
                        r_idx   <= r_pos - PSW'(1);
                        r_c     <= '0;
                        r_full  <= 1'b0;
                        r_phase <= PH_TAIL;
                        r_state <= S_JGO;
                    end else begin
                        if (r_pos < POS_MAX) begin
                            r_pos <= r_pos + PSW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_SUMMARY: begin
                    if (out_free) begin
                        r_out_valid            <= 1'b1;
                        r_out_data.kind        <= pft_pkg::KIND_SUMMARY;
                        r_out_data.start_index <= '0;
                        r_out_data.pulse_count <= r_count;
                        r_out_data.status      <= r_status;
                        r_out_data.last        <= 1'b1;
                        // clear island state, keep configuration
                        r_sum    <= '0;
                        r_sq_sum <= '0;
                        r_r0     <= '0;
                        r_r1     <= '0;
                        r_pos    <= '0;
                        r_open   <= 1'b0;
                        r_count  <= '0;
                        r_status <= pft_pkg::STATUS_OK;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_judge_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        jdone |-> (r_state == S_JWAIT))
        else $error("judge result arrived outside the wait state");

    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_MAX)
        else $error("sample position ran past the island limit");

    a_summary_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data.kind == pft_pkg::KIND_SUMMARY)) |-> r_out_data.last)
        else $error("summary result without last flag");

    a_stalled_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result_ch.ready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("stalled result overwritten");

    a_short_status_no_pulses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data.status == pft_pkg::STATUS_SHORT))
            |-> (r_out_data.pulse_count == '0))
        else $error("short island reported pulses");
`endif

endmodule
`default_nettype wire
